### hdl/bev_pkg.sv
`default_nettype none
package bev_pkg;

  localparam int NUM_BUTTONS = 5;
  localparam int BIT_PHASE_A = 5;
  localparam int BIT_PHASE_B = 6;
  localparam int SLOT_SCROLL = 5;
  localparam int SLOT_NONE   = 6;
  localparam int NUM_SLOTS   = 7;

  localparam logic [1:0] KIND_DOWN   = 2'd0;
  localparam logic [1:0] KIND_UP     = 2'd1;
  localparam logic [1:0] KIND_SCROLL = 2'd2;
  localparam logic [1:0] KIND_NONE   = 2'd3;

  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_A    = 2'd1;
  localparam logic [1:0] PEND_B    = 2'd2;

  localparam logic [2:0] CODE_SELECT = 3'd0;
  localparam logic [2:0] CODE_DOWN   = 3'd1;
  localparam logic [2:0] CODE_RIGHT  = 3'd2;
  localparam logic [2:0] CODE_UP     = 3'd3;
  localparam logic [2:0] CODE_LEFT   = 3'd4;

  localparam logic DIR_CW  = 1'b0;
  localparam logic DIR_CCW = 1'b1;

  typedef struct packed {
    logic [NUM_BUTTONS-1:0] btn_mask;
    logic [NUM_BUTTONS-1:0] btn_up;
    logic                   scroll;
    logic                   scroll_dir;
    logic                   remap;
  } job_t;

  function automatic logic [2:0] rotated_code(input logic [2:0] pin_idx);
    logic [2:0] code;
    code = CODE_SELECT;
    unique case (pin_idx)
      CODE_SELECT: code = CODE_SELECT;
      CODE_DOWN:   code = CODE_RIGHT;
      CODE_RIGHT:  code = CODE_UP;
      CODE_UP:     code = CODE_LEFT;
      CODE_LEFT:   code = CODE_DOWN;
      default:     code = CODE_SELECT;
    endcase
    return code;
  endfunction

endpackage
`default_nettype wire

### hdl/bev_front.sv
`default_nettype none
module bev_front #(
  parameter int PIN_WIDTH = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 accept,
  input  wire logic [PIN_WIDTH-1:0] pin_word,
  input  wire logic                 remap,
  output bev_pkg::job_t             job
);

  logic [PIN_WIDTH-1:0] previous_pins;
  logic [1:0]           pending_phase;
  logic [1:0]           pending_phase_next;
  logic [PIN_WIDTH-1:0] changes;
  logic                 ch_a;
  logic                 ch_b;

  assign changes = previous_pins ^ pin_word;
  assign ch_a    = changes[bev_pkg::BIT_PHASE_A];
  assign ch_b    = changes[bev_pkg::BIT_PHASE_B];

  always_comb begin
    job.btn_mask   = changes[bev_pkg::NUM_BUTTONS-1:0];
    job.btn_up     = pin_word[bev_pkg::NUM_BUTTONS-1:0];
    job.remap      = remap;
    job.scroll     = 1'b0;
    job.scroll_dir = bev_pkg::DIR_CW;
    pending_phase_next = pending_phase;
    if (ch_a || ch_b) begin
      if (pending_phase != bev_pkg::PEND_NONE) begin
        if (pending_phase == bev_pkg::PEND_A && ch_b) begin
          job.scroll = 1'b1;
        end else if (pending_phase == bev_pkg::PEND_B && ch_a) begin
          job.scroll     = 1'b1;
          job.scroll_dir = bev_pkg::DIR_CCW;
        end
        pending_phase_next = bev_pkg::PEND_NONE;
      end else begin
        pending_phase_next = ch_a ? bev_pkg::PEND_A : bev_pkg::PEND_B;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_pins <= '1;
      pending_phase <= bev_pkg::PEND_NONE;
    end else if (accept) begin
      previous_pins <= pin_word;
      pending_phase <= pending_phase_next;
    end
  end

endmodule
`default_nettype wire

### hdl/bev_queue.sv
`default_nettype none
module bev_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire bev_pkg::job_t push_job,
  output logic               full,
  input  wire logic          pop,
  output logic               q_valid,
  output bev_pkg::job_t      q_job
);

  localparam int DEPTH = 2;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  bev_pkg::job_t     slots [DEPTH];
  logic [PW-1:0]     wr_ptr;
  logic [PW-1:0]     rd_ptr;
  logic [CW-1:0]     count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == CW'(DEPTH));
  assign q_valid = (count != '0);
  assign q_job   = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

### hdl/bev_back.sv
`default_nettype none
module bev_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_valid,
  input  wire bev_pkg::job_t q_job,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [1:0]         event_kind,
  output logic [2:0]         button_code,
  output logic               scroll_dir,
  output logic               last_event
);

  logic [bev_pkg::NUM_SLOTS-1:0]   work_mask;
  logic [bev_pkg::NUM_SLOTS-1:0]   work_mask_next;
  logic [bev_pkg::NUM_SLOTS-1:0]   rest;
  logic [bev_pkg::NUM_SLOTS-1:0]   load_mask;
  logic [bev_pkg::NUM_BUTTONS-1:0] work_up;
  logic                            work_dir;
  logic                            work_remap;
  logic [2:0]                      idx;
  logic                            advance;
  logic                            emit;
  logic                            finishing;
  logic [1:0]                      kind_sel;
  logic [2:0]                      code_sel;
  logic                            dir_sel;

  assign advance   = !out_valid || !out_stall;
  assign emit      = (work_mask != '0) && advance;
  assign finishing = emit && (rest == '0);
  assign pop       = q_valid && ((work_mask == '0) || finishing);
  assign load_mask = {(q_job.btn_mask == '0) && !q_job.scroll, q_job.scroll, q_job.btn_mask};

  // lowest pending slot goes first
  always_comb begin
    idx = 3'(bev_pkg::NUM_SLOTS - 1);
    for (int i = bev_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
      if (work_mask[i]) begin
        idx = 3'(i);
      end
    end
    rest = work_mask & ~(bev_pkg::NUM_SLOTS'(1) << idx);
  end

  always_comb begin
    kind_sel = bev_pkg::KIND_NONE;
    code_sel = bev_pkg::CODE_SELECT;
    dir_sel  = bev_pkg::DIR_CW;
    if (idx == 3'(bev_pkg::SLOT_SCROLL)) begin
      kind_sel = bev_pkg::KIND_SCROLL;
      dir_sel  = work_dir;
    end else if (idx < 3'(bev_pkg::NUM_BUTTONS)) begin
      kind_sel = work_up[idx] ? bev_pkg::KIND_UP : bev_pkg::KIND_DOWN;
      code_sel = work_remap ? bev_pkg::rotated_code(idx) : idx;
    end
  end

  always_comb begin
    work_mask_next = work_mask;
    if (pop) begin
      work_mask_next = load_mask;
    end else if (emit) begin
      work_mask_next = rest;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      work_up    <= q_job.btn_up;
      work_dir   <= q_job.scroll_dir;
      work_remap <= q_job.remap;
    end
    if (emit) begin
      event_kind  <= kind_sel;
      button_code <= code_sel;
      scroll_dir  <= dir_sel;
      last_event  <= (rest == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      work_mask <= '0;
      out_valid <= 1'b0;
    end else begin
      work_mask <= work_mask_next;
      if (advance) begin
        out_valid <= emit;
      end
    end
  end

endmodule
`default_nettype wire

### hdl/button_events_and_rotary_decoder.sv
// throughput: one result per cycle while out_stall is low; a sample gives max(1, events) results, at most 6
// the back end's serializer sets the rate; a 2-entry queue lets front and back stall apart
// reset (synchronous): previous pins all ones, no phase pending, arrow remap on,
// queue and output register empty
`default_nettype none
module button_events_and_rotary_decoder #(
  parameter int PIN_WIDTH = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [PIN_WIDTH-1:0] pin_word,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic                 cfg_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [1:0]                event_kind,
  output logic [2:0]                button_code,
  output logic                      scroll_dir,
  output logic                      last_event
);

  logic          remap_arrows;
  logic          accept;
  logic          q_full;
  logic          q_valid;
  logic          pop;
  bev_pkg::job_t front_job;
  bev_pkg::job_t q_job;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      remap_arrows <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      remap_arrows <= cfg_data;
    end
  end

  bev_front #(.PIN_WIDTH(PIN_WIDTH)) u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .pin_word (pin_word),
    .remap    (remap_arrows),
    .job      (front_job)
  );

  bev_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (accept),
    .push_job (front_job),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_job    (q_job)
  );

  bev_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_job       (q_job),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .event_kind  (event_kind),
    .button_code (button_code),
    .scroll_dir  (scroll_dir),
    .last_event  (last_event)
  );

endmodule
`default_nettype wire

### hdl/bev_check.sv
`default_nettype none
module bev_check (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [1:0] event_kind,
  input wire logic [2:0] button_code,
  input wire logic       scroll_dir,
  input wire logic       last_event
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(event_kind) && $stable(button_code)
      && $stable(scroll_dir) && $stable(last_event))
    else $error("stalled result changed");

  a_quiet_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind == bev_pkg::KIND_NONE |-> last_event && button_code == 3'd0
      && scroll_dir == bev_pkg::DIR_CW)
    else $error("quiet result malformed");

  a_code_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> button_code <= bev_pkg::CODE_LEFT)
    else $error("button code out of range");

  a_scroll_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind == bev_pkg::KIND_SCROLL |-> button_code == 3'd0)
    else $error("scroll result carries a button code");

  a_button_dir: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_kind == bev_pkg::KIND_DOWN || event_kind == bev_pkg::KIND_UP)
      |-> scroll_dir == bev_pkg::DIR_CW)
    else $error("button result carries a direction");

endmodule

bind button_events_and_rotary_decoder bev_check u_check (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .event_kind  (event_kind),
  .button_code (button_code),
  .scroll_dir  (scroll_dir),
  .last_event  (last_event)
);
`default_nettype wire

### verif/tb_button_events_and_rotary_decoder.sv
`timescale 1ns / 1ps
module tb_button_events_and_rotary_decoder;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] code;
    logic       dir;
    logic       last;
  } btn_event_t;

  localparam logic [2:0] ROTATED [bev_pkg::NUM_BUTTONS] =
    '{bev_pkg::CODE_SELECT, bev_pkg::CODE_RIGHT, bev_pkg::CODE_UP, bev_pkg::CODE_LEFT,
      bev_pkg::CODE_DOWN};

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] pin_word = 8'hFF;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_data = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] event_kind;
  logic [2:0] button_code;
  logic       scroll_dir;
  logic       last_event;

  btn_event_t queued_events[$];
  logic [7:0] model_prev;
  logic [1:0] model_pend;
  logic       model_remap;
  logic [7:0] cur_word;
  logic       spin_cw;
  logic       phase_turn;
  int         mismatches = 0;
  int         send_idle_pct = 0;
  int         stall_pct = 0;

  button_events_and_rotary_decoder dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .pin_word(pin_word),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_stall(out_stall),
    .event_kind(event_kind), .button_code(button_code),
    .scroll_dir(scroll_dir), .last_event(last_event)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endtask

  // events caused by one pin sample
  function automatic void decode_sample(input logic [7:0] now);
    btn_event_t batch [6];
    logic [7:0] delta;
    int n;
    int b;
    delta = model_prev ^ now;
    n = 0;
    for (b = 0; b < bev_pkg::NUM_BUTTONS; b++) begin
      if (delta[b]) begin
        batch[n] = '{now[b] ? bev_pkg::KIND_UP : bev_pkg::KIND_DOWN,
                     model_remap ? ROTATED[b] : 3'(b), bev_pkg::DIR_CW, 1'b0};
        n++;
      end
    end
    if (delta[bev_pkg::BIT_PHASE_A] || delta[bev_pkg::BIT_PHASE_B]) begin
      if (model_pend != bev_pkg::PEND_NONE) begin
        if (model_pend == bev_pkg::PEND_A && delta[bev_pkg::BIT_PHASE_B]) begin
          batch[n] = '{bev_pkg::KIND_SCROLL, bev_pkg::CODE_SELECT, bev_pkg::DIR_CW, 1'b0};
          n++;
        end else if (model_pend == bev_pkg::PEND_B && delta[bev_pkg::BIT_PHASE_A]) begin
          batch[n] = '{bev_pkg::KIND_SCROLL, bev_pkg::CODE_SELECT, bev_pkg::DIR_CCW, 1'b0};
          n++;
        end
        model_pend = bev_pkg::PEND_NONE;
      end else begin
        model_pend = delta[bev_pkg::BIT_PHASE_A] ? bev_pkg::PEND_A : bev_pkg::PEND_B;
      end
    end
    model_prev = now;
    if (n == 0) begin
      batch[0] = '{bev_pkg::KIND_NONE, bev_pkg::CODE_SELECT, bev_pkg::DIR_CW, 1'b0};
      n = 1;
    end
    for (b = 0; b < n; b++) begin
      batch[b].last = (b == n - 1);
      queued_events.push_back(batch[b]);
    end
  endfunction

  // one pin sample request
  task automatic send_pins(input logic [7:0] w);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    pin_word <= w;
    do @(posedge clk); while (in_stall);
    cur_word = w;
    decode_sample(w);
  endtask

  task automatic drain_events();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (queued_events.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    if (queued_events.size() != 0) begin
      note_mismatch($sformatf("%0d results never arrived", queued_events.size()));
      queued_events.delete();
    end
    repeat (6) @(posedge clk);
  endtask

  task automatic write_remap(input logic v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    model_remap = v;
  endtask

  always @(posedge clk) begin
    btn_event_t exp_ev;
    if (!rst && out_valid && !out_stall) begin
      if (queued_events.size() == 0) begin
        note_mismatch($sformatf("unexpected result kind=%0d code=%0d dir=%0d last=%0d",
                                event_kind, button_code, scroll_dir, last_event));
      end else begin
        exp_ev = queued_events.pop_front();
        if (exp_ev.kind !== event_kind || exp_ev.code !== button_code ||
            exp_ev.dir !== scroll_dir || exp_ev.last !== last_event)
          note_mismatch($sformatf(
            "expected kind=%0d code=%0d dir=%0d last=%0d, got %0d %0d %0d %0d",
            exp_ev.kind, exp_ev.code, exp_ev.dir, exp_ev.last,
            event_kind, button_code, scroll_dir, last_event));
      end
    end
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // reset value of the remap is left in place here
  task automatic test_quiet_and_extremes();
    send_pins(8'hFF);
    send_pins(8'h00);
    send_pins(8'hFF);
    send_pins(8'h7F);
  endtask

  task automatic test_rotary_sequences();
    send_pins(8'hDF);
    send_pins(8'h9F);
    send_pins(8'hDF);
    send_pins(8'hFF);
    send_pins(8'hDF);
    send_pins(8'hFF);
    send_pins(8'hBF);
    send_pins(8'hFF);
    send_pins(8'hBF);
    send_pins(8'h9F);
    send_pins(8'hFF);
    send_pins(8'hBF);
  endtask

  task automatic test_each_button(input logic remap);
    int b;
    drain_events();
    write_remap(remap);
    send_pins(8'hFF);
    for (b = 0; b < bev_pkg::NUM_BUTTONS; b++) begin
      send_pins(8'hFF & ~(8'd1 << b));
      send_pins(8'hFF);
    end
  endtask

  function automatic logic [7:0] next_pins();
    logic [7:0] w;
    int b;
    if ($urandom_range(99) < 20) return 8'($urandom);
    w = cur_word;
    for (b = 0; b < bev_pkg::NUM_BUTTONS; b++)
      if ($urandom_range(3) == 0) w[b] = ~w[b];
    if ($urandom_range(99) < 60) begin
      if ($urandom_range(19) == 0) spin_cw = ~spin_cw;
      if (spin_cw ^ phase_turn) w[bev_pkg::BIT_PHASE_A] = ~w[bev_pkg::BIT_PHASE_A];
      else w[bev_pkg::BIT_PHASE_B] = ~w[bev_pkg::BIT_PHASE_B];
      phase_turn = ~phase_turn;
    end
    w[7] = 1'($urandom_range(1));
    return w;
  endfunction

  task automatic test_random_traffic(input int n, input int idle_pct, input int stall_p,
                                     input logic remap);
    drain_events();
    write_remap(remap);
    send_idle_pct = idle_pct;
    stall_pct = stall_p;
    repeat (n) send_pins(next_pins());
    drain_events();
    send_idle_pct = 0;
    stall_pct = 0;
  endtask

  initial begin
    model_prev = 8'hFF;
    model_pend = bev_pkg::PEND_NONE;
    model_remap = 1'b1;
    cur_word = 8'hFF;
    spin_cw = 1'b1;
    phase_turn = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_quiet_and_extremes();
    test_rotary_sequences();
    test_each_button(1'b0);
    test_random_traffic(120, 0, 0, 1'b1);
    test_random_traffic(120, 72, 0, 1'b0);
    test_random_traffic(120, 0, 72, 1'($urandom_range(1)));
    test_random_traffic(120, 29, 29, 1'b1);
    drain_events();
    if (mismatches == 0) begin
      $display("tb_button_events_and_rotary_decoder: clean");
    end else begin
      $display("tb_button_events_and_rotary_decoder: errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_button_events_and_rotary_decoder: errors");
    $finish;
  end

endmodule
